/* rtl/grid_local_peak_finder_defines.svh */
// ------------------------------------------------------------------------
// Assertion macros for the grid local peak finder
// Shared property forms used by the checks at the end of the top level.
// ------------------------------------------------------------------------
`ifndef GRID_LOCAL_PEAK_FINDER_DEFINES_SVH
`define GRID_LOCAL_PEAK_FINDER_DEFINES_SVH

// The condition pre on one edge implies post on the next edge.
`define GLPF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("grid peak finder: next-cycle check failed");

// The condition pre implies post on the same edge.
`define GLPF_ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("grid peak finder: same-cycle check failed");

`endif

/* rtl/glpf_pkg.sv */
// ------------------------------------------------------------------------
// Grid local peak finder package
// Field widths, register and command codes, and the structs that pass
// between the sequencer, the decision stage and the top level.
// ------------------------------------------------------------------------
package glpf_pkg;

	// Configuration register layout.
	localparam int CFG_BITS      = 6;
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 3;
	localparam logic [CFG_BITS-1:0] CFG_RESET = 6'd2;
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	// Input command codes.
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// Width of a reported coordinate.
	localparam int COORD_BITS = 5;

	// One cell decision as the sequencer issues it.
	typedef struct packed {
		logic                  decide;
		logic                  has_down;
		logic                  has_left;
		logic                  has_right;
		logic                  has_up;
		logic                  parity;
		logic [COORD_BITS-1:0] row;
		logic [COORD_BITS-1:0] col;
	} glpf_item_t;

	// Line store strobes for one cycle.
	typedef struct packed {
		logic we_a;
		logic we_b;
		logic re;
	} glpf_ram_ctl_t;

	// Decision stage status seen by the top level.
	typedef struct packed {
		logic s1_valid;
		logic s1_hit;
	} glpf_stage_t;

endpackage

/* rtl/glpf_if.sv */
// ------------------------------------------------------------------------
// Grid local peak finder stream interfaces
// Valid/ready channels for pixel input and peak results.
// ------------------------------------------------------------------------
interface glpf_pix_if #(
	parameter int VALUE_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic [VALUE_BITS-1:0] pixel_value;

	modport source (output valid, command, pixel_value, input ready);
	modport sink (input valid, command, pixel_value, output ready);
endinterface

interface glpf_peak_if;
	import glpf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] peak_row;
	logic [COORD_BITS-1:0] peak_col;

	modport source (output valid, peak_row, peak_col, input ready);
	modport sink (input valid, peak_row, peak_col, output ready);
endinterface

/* rtl/glpf_ram.sv */
// ------------------------------------------------------------------------
// Generic line store RAM
// One write port and two read ports with registered, read-first data.
// ------------------------------------------------------------------------
module glpf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);
	logic [WIDTH-1:0] mem [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end
endmodule

/* rtl/glpf_cfg.sv */
// ------------------------------------------------------------------------
// Grid local peak finder configuration registers
// APB-style access to grid width and height, clamped on write.
// ------------------------------------------------------------------------
module glpf_cfg #(
	parameter int MAX_WIDTH  = 32,
	parameter int MAX_HEIGHT = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [glpf_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [glpf_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [glpf_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                               pready,
	output logic [glpf_pkg::CFG_BITS-1:0]      grid_width,
	output logic [glpf_pkg::CFG_BITS-1:0]      grid_height,
	output logic                               cfg_clear
);
	import glpf_pkg::*;

	logic [CFG_BITS-1:0] width_q;
	logic [CFG_BITS-1:0] height_q;
	logic [CFG_BITS-1:0] wvalue;
	logic                wr_en;

	function automatic logic [CFG_BITS-1:0] clamp_dim(input logic [CFG_BITS-1:0] v,
			input int hi);
		logic [CFG_BITS-1:0] res;
		if (v < CFG_RESET) begin
			res = CFG_RESET;
		end else if (int'(v) > hi) begin
			res = CFG_BITS'(hi);
		end else begin
			res = v;
		end
		return res;
	endfunction

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign wvalue = pwdata[CFG_BITS-1:0];

	// Any write to a listed register restarts the grid.
	assign cfg_clear = wr_en;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_RESET;
			height_q <= CFG_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_GRID_WIDTH:  width_q  <= clamp_dim(wvalue, MAX_WIDTH);
				REG_GRID_HEIGHT: height_q <= clamp_dim(wvalue, MAX_HEIGHT);
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		case (paddr[2])
			REG_GRID_WIDTH:  prdata = APB_DATA_BITS'(width_q);
			REG_GRID_HEIGHT: prdata = APB_DATA_BITS'(height_q);
			default:         prdata = '0;
		endcase
	end

	assign grid_width  = width_q;
	assign grid_height = height_q;
endmodule

/* rtl/glpf_seq.sv */
// ------------------------------------------------------------------------
// Grid local peak finder sequencer
// Raster and flush counters, line store addressing and decision setup.
// ------------------------------------------------------------------------
module glpf_seq #(
	parameter int MAX_WIDTH  = 32,
	parameter int MAX_HEIGHT = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          command,
	input  logic [glpf_pkg::CFG_BITS-1:0] grid_width,
	input  logic [glpf_pkg::CFG_BITS-1:0] grid_height,
	input  logic                          cfg_clear,
	output glpf_pkg::glpf_item_t          item,
	output glpf_pkg::glpf_ram_ctl_t       ram_ctl,
	output logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
	output logic [$clog2(MAX_WIDTH)-1:0]  rd_addr0,
	output logic [$clog2(MAX_WIDTH)-1:0]  rd_addr1
);
	import glpf_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	logic [HW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [CW-1:0] flush_q;

	logic [31:0] w, h, row, col, fc, c, r;
	logic        is_pix, pix_eff, fl_eff;

	// Decode the incoming item against the counters.
	always_comb begin
		w       = 32'(grid_width);
		h       = 32'(grid_height);
		row     = 32'(row_q);
		col     = 32'(col_q);
		fc      = 32'(flush_q);
		is_pix  = (command == CMD_PIXEL);
		pix_eff = is_pix && (row < h) && (col < w);
		fl_eff  = !is_pix && (row == h) && (fc < w);
		c       = is_pix ? col : fc;
		r       = is_pix ? (row - 32'd1) : (h - 32'd1);

		item.decide    = (pix_eff && (row != 32'd0)) || fl_eff;
		item.has_down  = is_pix;
		item.has_left  = (c != 32'd0);
		item.has_right = ((c + 32'd1) < w);
		item.has_up    = (r != 32'd0);
		item.parity    = r[0];
		item.row       = COORD_BITS'(r);
		item.col       = COORD_BITS'(c);

		ram_ctl.we_a = accept && pix_eff && !row_q[0];
		ram_ctl.we_b = accept && pix_eff && row_q[0];
		ram_ctl.re   = accept && item.decide;
		wr_addr      = col_q;
		rd_addr0     = CW'(c);
		rd_addr1     = CW'(c + 32'd1);
	end

	// Counter update on each transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			flush_q <= '0;
		end else if (cfg_clear) begin
			row_q   <= '0;
			col_q   <= '0;
			flush_q <= '0;
		end else if (accept) begin
			if (pix_eff) begin
				if ((col + 32'd1) >= w) begin
					col_q <= '0;
					row_q <= HW'(row + 32'd1);
				end else begin
					col_q <= CW'(col + 32'd1);
				end
			end
			if (fl_eff) begin
				if ((fc + 32'd1) >= w) begin
					row_q   <= '0;
					col_q   <= '0;
					flush_q <= '0;
				end else begin
					flush_q <= CW'(fc + 32'd1);
				end
			end
		end
	end
endmodule

/* rtl/glpf_decide.sv */
// ------------------------------------------------------------------------
// Grid local peak finder decision stage
// Compares a cell with its neighbors and holds the result register.
// ------------------------------------------------------------------------
module glpf_decide #(
	parameter int VALUE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  glpf_pkg::glpf_item_t            item,
	input  logic [VALUE_BITS-1:0]           down_value,
	input  logic [VALUE_BITS-1:0]           a_rd0,
	input  logic [VALUE_BITS-1:0]           a_rd1,
	input  logic [VALUE_BITS-1:0]           b_rd0,
	input  logic [VALUE_BITS-1:0]           b_rd1,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [glpf_pkg::COORD_BITS-1:0] out_row,
	output logic [glpf_pkg::COORD_BITS-1:0] out_col,
	output logic                            in_ready,
	output glpf_pkg::glpf_stage_t           status
);
	import glpf_pkg::*;

	logic                  valid_s1;
	glpf_item_t            item_s1;
	logic [VALUE_BITS-1:0] down_s1;
	logic [VALUE_BITS-1:0] left_q;
	logic                  valid_s2;
	logic [COORD_BITS-1:0] row_s2;
	logic [COORD_BITS-1:0] col_s2;

	logic [VALUE_BITS-1:0] center, right_v, above;
	logic                  hit, s1_adv;

	// The result register frees stage one whenever it is empty or taken.
	assign s1_adv   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || s1_adv;

	// Pick the current and upper rows by parity.
	always_comb begin
		center  = item_s1.parity ? b_rd0 : a_rd0;
		right_v = item_s1.parity ? b_rd1 : a_rd1;
		above   = item_s1.parity ? a_rd0 : b_rd0;
		hit = (!item_s1.has_down  || (center >= down_s1)) &&
		      (!item_s1.has_left  || (center >= left_q)) &&
		      (!item_s1.has_right || (center >= right_v)) &&
		      (!item_s1.has_up    || (center >= above));
	end

	// Stage one control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= item.decide;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage one payload; the center of a leaving cell is the next left neighbor.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			down_s1 <= down_value;
		end
		if (valid_s1 && s1_adv) begin
			left_q <= center;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= valid_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			row_s2 <= item_s1.row;
			col_s2 <= item_s1.col;
		end
	end

	assign out_valid       = valid_s2;
	assign out_row         = row_s2;
	assign out_col         = col_s2;
	assign status.s1_valid = valid_s1;
	assign status.s1_hit   = hit;
endmodule

/* rtl/grid_local_peak_finder.sv */
// ------------------------------------------------------------------------
// Grid local peak finder
// Four-neighbor local maximum detection on a raster-order grid stream.
//
//   Port group  Dir   Content
//   pixel       in    command, pixel_value (valid/ready)
//   peak        out   peak_row, peak_col (valid/ready)
//   APB         in    grid_width at 0x0, grid_height at 0x4
//
// One item is taken every cycle unless the input stalls. A deciding
// transfer reads the line stores into the compare stage, then compares
// into the result register. The pixel input stalls only when both the
// compare stage and the result register hold items. Reset clears counters
// and handshake state; the line stores are not cleared and need no sweep.
// ------------------------------------------------------------------------
`include "grid_local_peak_finder_defines.svh"

module grid_local_peak_finder #(
	parameter int MAX_WIDTH  = 32,
	parameter int MAX_HEIGHT = 32,
	parameter int VALUE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [glpf_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [glpf_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [glpf_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                               pready,
	glpf_pix_if.sink                           pixel,
	glpf_peak_if.source                        peak
);
	import glpf_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic [CFG_BITS-1:0]   grid_width;
	logic [CFG_BITS-1:0]   grid_height;
	logic                  cfg_clear;
	logic                  accept;
	logic                  in_ready;
	glpf_item_t            item;
	glpf_ram_ctl_t         ram_ctl;
	glpf_stage_t           status;
	logic [AW-1:0]         wr_addr, rd_addr0, rd_addr1;
	logic [VALUE_BITS-1:0] pix_val;
	logic [VALUE_BITS-1:0] a_rd0, a_rd1, b_rd0, b_rd1;

	assign pixel.ready = in_ready;
	assign accept      = pixel.valid && in_ready;
	assign pix_val     = pixel.pixel_value;

	// Configuration registers.
	glpf_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.grid_width  (grid_width),
		.grid_height (grid_height),
		.cfg_clear   (cfg_clear)
	);

	// Raster counters and store addressing.
	glpf_seq #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.command     (pixel.command),
		.grid_width  (grid_width),
		.grid_height (grid_height),
		.cfg_clear   (cfg_clear),
		.item        (item),
		.ram_ctl     (ram_ctl),
		.wr_addr     (wr_addr),
		.rd_addr0    (rd_addr0),
		.rd_addr1    (rd_addr1)
	);

	// Line store for even rows.
	glpf_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (MAX_WIDTH)
	) u_store_a (
		.clk    (clk),
		.we     (ram_ctl.we_a),
		.waddr  (wr_addr),
		.wdata  (pix_val),
		.re     (ram_ctl.re),
		.raddr0 (rd_addr0),
		.raddr1 (rd_addr1),
		.rdata0 (a_rd0),
		.rdata1 (a_rd1)
	);

	// Line store for odd rows.
	glpf_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (MAX_WIDTH)
	) u_store_b (
		.clk    (clk),
		.we     (ram_ctl.we_b),
		.waddr  (wr_addr),
		.wdata  (pix_val),
		.re     (ram_ctl.re),
		.raddr0 (rd_addr0),
		.raddr1 (rd_addr1),
		.rdata0 (b_rd0),
		.rdata1 (b_rd1)
	);

	// Neighbor compare and result register.
	glpf_decide #(
		.VALUE_BITS (VALUE_BITS)
	) u_decide (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.down_value (pix_val),
		.a_rd0      (a_rd0),
		.a_rd1      (a_rd1),
		.b_rd0      (b_rd0),
		.b_rd1      (b_rd1),
		.out_ready  (peak.ready),
		.out_valid  (peak.valid),
		.out_row    (peak.peak_row),
		.out_col    (peak.peak_col),
		.in_ready   (in_ready),
		.status     (status)
	);

	// A deciding transfer always lands in the compare stage.
	`GLPF_ASSERT_NEXT(a_decide_loads, clk, arst_n, accept && item.decide, status.s1_valid)
	// A hit leaving the compare stage shows up as a result.
	`GLPF_ASSERT_NEXT(a_hit_reported, clk, arst_n,
		status.s1_valid && status.s1_hit && (!peak.valid || peak.ready), peak.valid)
	// An empty compare stage never produces a result.
	`GLPF_ASSERT_NEXT(a_no_phantom, clk, arst_n,
		!status.s1_valid && (!peak.valid || peak.ready), !peak.valid)
	// Input back-pressure only comes from a full, stalled pipeline.
	`GLPF_ASSERT_SAME(a_stall_cause, clk, arst_n, !pixel.ready,
		status.s1_valid && peak.valid && !peak.ready)
endmodule

/* test/glpf_peak_checker.sv */
// ------------------------------------------------------------------------
// Grid local peak finder checker
// Watches the pixel, peak and APB ports. It keeps its own copy of the
// line stores and counters, works out which cells are peaks, and compares
// every peak transfer with the oldest predicted coordinate.
// ------------------------------------------------------------------------
module glpf_peak_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic                               pready,
	input  logic [glpf_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [glpf_pkg::APB_DATA_BITS-1:0] pwdata,
	glpf_pix_if                                pixel,
	glpf_peak_if                               peak,
	output int                                 failures,
	output int                                 outstanding
);
	import glpf_pkg::*;

	localparam int GRID_MAX = 32;

	typedef struct packed {
		logic [COORD_BITS-1:0] row;
		logic [COORD_BITS-1:0] col;
	} peak_pos_t;

	// Predicted peaks, oldest first.
	peak_pos_t expected_peaks[$];
	peak_pos_t oldest_peak;

	// Rows alternate between the two stores by row parity.
	logic [15:0] even_rows[GRID_MAX];
	logic [15:0] odd_rows[GRID_MAX];

	int cols;
	int rows;
	int rows_in;
	int col_next;
	int flushes_in;

	function automatic logic [15:0] stored(int r, int c);
		return r[0] ? odd_rows[c] : even_rows[c];
	endfunction

	function automatic void keep_cell(int r, int c, logic [15:0] v);
		if (r[0])
			odd_rows[c] = v;
		else
			even_rows[c] = v;
	endfunction

	function automatic int clamp_size(logic [CFG_BITS-1:0] v);
		if (v < 2)
			return 2;
		if (v > GRID_MAX)
			return GRID_MAX;
		return int'(v);
	endfunction

	// A cell is a peak when it is not below any neighbor that exists.
	function automatic bit cell_is_peak(int r, int c, bit has_down, logic [15:0] down);
		logic [15:0] v;
		bit          ok;
		v  = stored(r, c);
		ok = 1'b1;
		if (has_down && v < down)
			ok = 1'b0;
		if (c > 0 && v < stored(r, c - 1))
			ok = 1'b0;
		if (c + 1 < cols && v < stored(r, c + 1))
			ok = 1'b0;
		if (r > 0 && v < stored(r - 1, c))
			ok = 1'b0;
		return ok;
	endfunction

	function automatic void clear_counts();
		rows_in    = 0;
		col_next   = 0;
		flushes_in = 0;
	endfunction

	function automatic void add_peak(int r, int c);
		peak_pos_t p;
		p.row = COORD_BITS'(r);
		p.col = COORD_BITS'(c);
		expected_peaks.push_back(p);
	endfunction

	// Advance the grid state by one accepted item.
	function automatic void take_item(logic cmd, logic [15:0] val);
		int c;
		if (cmd == CMD_PIXEL) begin
			c = col_next;
			if (rows_in >= rows || c >= cols)
				return;
			if (rows_in == 0) begin
				keep_cell(0, c, val);
			end else begin
				if (cell_is_peak(rows_in - 1, c, 1'b1, val))
					add_peak(rows_in - 1, c);
				keep_cell(rows_in, c, val);
			end
			col_next = c + 1;
			if (col_next >= cols) begin
				col_next = 0;
				rows_in++;
			end
		end else begin
			c = flushes_in;
			if (rows_in != rows || c >= cols)
				return;
			if (cell_is_peak(rows - 1, c, 1'b0, '0))
				add_peak(rows - 1, c);
			flushes_in = c + 1;
			if (flushes_in >= cols)
				clear_counts();
		end
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t peak check: %s", $time, what);
		failures++;
	endtask

	// Compare results, follow register writes and predict per transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols = int'(CFG_RESET);
			rows = int'(CFG_RESET);
			clear_counts();
			expected_peaks.delete();
			failures = 0;
			outstanding <= 0;
		end else begin
			if (peak.valid && peak.ready) begin
				if (expected_peaks.size() == 0) begin
					report_mismatch($sformatf("peak (%0d,%0d) with none predicted",
						peak.peak_row, peak.peak_col));
				end else begin
					oldest_peak = expected_peaks.pop_front();
					if (oldest_peak.row != peak.peak_row || oldest_peak.col != peak.peak_col)
						report_mismatch($sformatf("peak (%0d,%0d), predicted (%0d,%0d)",
							peak.peak_row, peak.peak_col, oldest_peak.row, oldest_peak.col));
				end
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_GRID_WIDTH, 2'b00}) begin
					cols = clamp_size(pwdata[CFG_BITS-1:0]);
					clear_counts();
				end else if (paddr == {REG_GRID_HEIGHT, 2'b00}) begin
					rows = clamp_size(pwdata[CFG_BITS-1:0]);
					clear_counts();
				end
			end
			if (pixel.valid && pixel.ready)
				take_item(pixel.command, pixel.pixel_value);
			outstanding <= expected_peaks.size();
		end
	end

endmodule

/* test/tb_grid_local_peak_finder.sv */
// ------------------------------------------------------------------------
// Grid local peak finder testbench
// Streams grids of many sizes, with ignored pixels and early flushes mixed
// in, under random gaps and stalls on both channels, and reprograms the
// grid size between grids. A checker beside the block predicts the peaks.
// ------------------------------------------------------------------------
module tb_grid_local_peak_finder;
	import glpf_pkg::*;

	localparam int HOLD_CYCLES   = 400;
	localparam int IDLE_LIMIT    = 5000;
	localparam int ITEM_TARGET   = 650;
	localparam int SETTLE_CYCLES = 6;
	localparam int MAX_GAP       = 17;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	int failures;
	int outstanding;
	int idle_cycles = 0;
	int item_total  = 0;
	bit hold_req    = 1'b0;
	bit send_fast   = 1'b0;

	glpf_pix_if #(.VALUE_BITS(16)) pixel_ch ();
	glpf_peak_if                   peak_ch ();

	grid_local_peak_finder u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pixel   (pixel_ch),
		.peak    (peak_ch)
	);

	glpf_peak_checker u_peak_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pixel       (pixel_ch),
		.peak        (peak_ch),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always #10 clk = ~clk;

	// Stop the run when nothing has been accepted for too long.
	always @(posedge clk) begin
		if ((pixel_ch.valid && pixel_ch.ready) || (peak_ch.valid && peak_ch.ready) ||
				(psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d cycles without a transfer", idle_cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// Gap before an item; often zero so that bursts occur.
	function automatic int pick_gap(bit fast);
		if (fast || $urandom_range(3) == 0)
			return 0;
		return $urandom_range(MAX_GAP);
	endfunction

	// Result side: a random, often zero, stall before every transfer, one long hold on request.
	initial begin
		int gap;
		int served;
		bit ready_fast;
		served     = 0;
		ready_fast = 1'b0;
		forever begin
			gap = pick_gap(ready_fast);
			if (hold_req) begin
				hold_req = 1'b0;
				gap      = HOLD_CYCLES;
			end
			if (gap > 0) begin
				peak_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			peak_ch.ready <= 1'b1;
			@(posedge clk);
			while (!peak_ch.valid)
				@(posedge clk);
			served++;
			if (served % 40 == 0)
				ready_fast = ($urandom_range(3) == 0);
		end
	end

	// Offer one item after a random gap and wait for its transfer.
	task automatic send_item(input logic cmd, input logic [15:0] val);
		int gap;
		gap = pick_gap(send_fast);
		if (gap > 0) begin
			pixel_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_ch.valid       <= 1'b1;
		pixel_ch.command     <= cmd;
		pixel_ch.pixel_value <= val;
		@(posedge clk);
		while (!pixel_ch.ready)
			@(posedge clk);
	endtask

	// Stop sending until every predicted peak has come out.
	task automatic settle();
		pixel_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, access cycle, then release the bus.
	task automatic write_reg(input logic idx, input logic [CFG_BITS-1:0] low);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {(APB_DATA_BITS - CFG_BITS)'($urandom()), low};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Sizes at the limits are sometimes written out of range to exercise clamping.
	function automatic logic [CFG_BITS-1:0] encode_size(int n);
		if (n == 2 && $urandom_range(2) == 0)
			return CFG_BITS'($urandom_range(1));
		if (n == 32 && $urandom_range(2) == 0)
			return CFG_BITS'($urandom_range(63, 33));
		return CFG_BITS'(n);
	endfunction

	task automatic set_grid(input int w, input int h);
		settle();
		if ($urandom_range(1)) begin
			write_reg(REG_GRID_WIDTH, encode_size(w));
			write_reg(REG_GRID_HEIGHT, encode_size(h));
		end else begin
			write_reg(REG_GRID_HEIGHT, encode_size(h));
			write_reg(REG_GRID_WIDTH, encode_size(w));
		end
	endtask

	// Value styles: narrow range for ties, full range, and the extremes.
	function automatic logic [15:0] pick_value(int kind);
		case (kind)
			0: begin
				return 16'($urandom_range(3));
			end
			1: begin
				return 16'($urandom_range(65535));
			end
			default: begin
				return $urandom_range(1) ? 16'hFFFF - 16'($urandom_range(1))
				                         : 16'($urandom_range(1));
			end
		endcase
	endfunction

	// One whole grid with its flushes, optionally with ignored items mixed in.
	task automatic run_grid(input int w, input int h, input int noise_pct, input int kind);
		int extra;
		for (int r = 0; r < h; r++) begin
			for (int c = 0; c < w; c++) begin
				if ($urandom_range(99) < noise_pct)
					send_item(CMD_FLUSH, 16'($urandom()));
				send_item(CMD_PIXEL, pick_value(kind));
			end
		end
		extra = (noise_pct > 0) ? $urandom_range(2) : 0;
		for (int i = 0; i < extra; i++)
			send_item(CMD_PIXEL, 16'($urandom()));
		for (int c = 0; c < w; c++)
			send_item(CMD_FLUSH, 16'($urandom()));
		item_total += w * h + w;
	endtask

	initial begin
		int w;
		int h;
		int kind;
		int mode;
		int phase;
		int partial;
		arst_n               <= 1'b0;
		psel                 <= 1'b0;
		penable              <= 1'b0;
		pwrite               <= 1'b0;
		paddr                <= '0;
		pwdata               <= '0;
		pixel_ch.valid       <= 1'b0;
		pixel_ch.command     <= CMD_PIXEL;
		pixel_ch.pixel_value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset size 2x2: early flush, extreme values, a pixel past the last row.
		send_item(CMD_FLUSH, 16'h1234);
		send_item(CMD_PIXEL, 16'hFFFF);
		send_item(CMD_PIXEL, 16'h0000);
		send_item(CMD_PIXEL, 16'h0000);
		send_item(CMD_PIXEL, 16'hFFFF);
		send_item(CMD_PIXEL, 16'h5555);
		send_item(CMD_FLUSH, 16'hAAAA);
		send_item(CMD_FLUSH, 16'h0000);

		// Flat grid: every cell ties with its neighbors.
		for (int i = 0; i < 4; i++)
			send_item(CMD_PIXEL, 16'h8000);
		send_item(CMD_FLUSH, 16'hFFFF);
		send_item(CMD_FLUSH, 16'h7FFF);

		// Width below range clamps to 2; a 2x3 ramp has its peak in the corner.
		settle();
		write_reg(REG_GRID_WIDTH, CFG_BITS'(1));
		write_reg(REG_GRID_HEIGHT, CFG_BITS'(3));
		for (int i = 1; i <= 6; i++)
			send_item(CMD_PIXEL, 16'(i));
		send_item(CMD_FLUSH, 16'h0F0F);
		send_item(CMD_FLUSH, 16'hF0F0);
		item_total = 22;

		// Random grids until enough items have been sent.
		phase = 0;
		while (item_total < ITEM_TARGET) begin
			send_fast = ($urandom_range(3) == 0);
			kind      = $urandom_range(2);
			if (phase == 0) begin
				w = 32;
				h = 2;
			end else if (phase == 1) begin
				w = 2;
				h = 32;
			end else if (phase == 2) begin
				w = 6;
				h = 6;
			end else if ($urandom_range(9) == 0) begin
				w = $urandom_range(1) ? 32 : $urandom_range(3, 2);
				h = (w == 32) ? $urandom_range(3, 2) : 32;
			end else begin
				w = $urandom_range(6, 2);
				h = $urandom_range(6, 2);
			end
			set_grid(w, h);
			// Long stall on the result side while pixels keep coming.
			if (phase == 2) begin
				hold_req  = 1'b1;
				send_fast = 1'b1;
				kind      = 0;
			end
			mode = $urandom_range(9);
			if (mode < 7) begin
				run_grid(w, h, $urandom_range(1) ? 0 : 10, kind);
			end else if (mode < 9) begin
				run_grid(w, h, 0, kind);
				run_grid(w, h, 0, $urandom_range(2));
			end else begin
				// Abandoned grid; the next size write starts over.
				partial = $urandom_range(w * h - 1, 1);
				for (int i = 0; i < partial; i++)
					send_item(CMD_PIXEL, pick_value(kind));
				item_total += partial;
			end
			phase++;
		end

		settle();
		repeat (10) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
